// ----- rtl/scd_pkg.sv -----
// Shared types, word kinds and set-1 layout tables for the scan code decoder.
`timescale 1ns / 1ps

package scd_pkg;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PUSH = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LCTRL      = 8'h1D;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;

	localparam logic [7:0] CH_CTRL_C = 8'd3;
	localparam logic [7:0] CH_CTRL_L = 8'd12;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic       intr;
		logic       clr;
	} scd_op_t;

	function automatic logic [7:0] plain_map(input logic [6:0] idx);
		logic [7:0] r;
		unique case (idx)
			7'd1:  r = 8'h01;
			7'd2:  r = 8'h31;
			7'd3:  r = 8'h32;
			7'd4:  r = 8'h33;
			7'd5:  r = 8'h34;
			7'd6:  r = 8'h35;
			7'd7:  r = 8'h36;
			7'd8:  r = 8'h37;
			7'd9:  r = 8'h38;
			7'd10: r = 8'h39;
			7'd11: r = 8'h30;
			7'd12: r = 8'h27;
			7'd13: r = 8'h3C;
			7'd14: r = 8'h08;
			7'd15: r = 8'h09;
			7'd16: r = 8'h71;
			7'd17: r = 8'h77;
			7'd18: r = 8'h65;
			7'd19: r = 8'h72;
			7'd20: r = 8'h74;
			7'd21: r = 8'h79;
			7'd22: r = 8'h75;
			7'd23: r = 8'h69;
			7'd24: r = 8'h6F;
			7'd25: r = 8'h70;
			7'd26: r = 8'h5C;
			7'd27: r = 8'h2B;
			7'd28: r = 8'h0A;
			7'd30: r = 8'h61;
			7'd31: r = 8'h73;
			7'd32: r = 8'h64;
			7'd33: r = 8'h66;
			7'd34: r = 8'h67;
			7'd35: r = 8'h68;
			7'd36: r = 8'h6A;
			7'd37: r = 8'h6B;
			7'd38: r = 8'h6C;
			7'd39: r = 8'h3B;
			7'd40: r = 8'h7B;
			7'd41: r = 8'h7C;
			7'd42: r = 8'h05;
			7'd43: r = 8'h7D;
			7'd44: r = 8'h7A;
			7'd45: r = 8'h78;
			7'd46: r = 8'h63;
			7'd47: r = 8'h76;
			7'd48: r = 8'h62;
			7'd49: r = 8'h6E;
			7'd50: r = 8'h6D;
			7'd51: r = 8'h2C;
			7'd52: r = 8'h2E;
			7'd53: r = 8'h2D;
			7'd55: r = 8'h2A;
			7'd57: r = 8'h20;
			7'd72: r = 8'd17;
			7'd75: r = 8'd18;
			7'd77: r = 8'd19;
			7'd80: r = 8'd20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Letters become upper case; only the punctuation that differs is listed.
	function automatic logic [7:0] shifted_map(input logic [6:0] idx);
		logic [7:0] base;
		logic [7:0] r;
		base = plain_map(idx);
		if (base >= 8'h61 && base <= 8'h7A) begin
			r = base - 8'h20;
		end else begin
			unique case (idx)
				7'd2:  r = 8'h21;
				7'd3:  r = 8'h22;
				7'd4:  r = 8'h23;
				7'd5:  r = 8'h24;
				7'd6:  r = 8'h25;
				7'd7:  r = 8'h26;
				7'd8:  r = 8'h2F;
				7'd9:  r = 8'h28;
				7'd10: r = 8'h29;
				7'd11: r = 8'h3D;
				7'd12: r = 8'h3F;
				7'd13: r = 8'h3E;
				7'd26: r = 8'h5E;
				7'd27: r = 8'h2A;
				7'd39: r = 8'h7E;
				7'd40: r = 8'h5B;
				7'd41: r = 8'h2F;
				7'd43: r = 8'h5D;
				7'd51: r = 8'h3B;
				7'd52: r = 8'h3A;
				7'd53: r = 8'h5F;
				default: r = base;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- rtl/scd_front.sv -----
// Front end: accepts words, tracks the modifier keys and classifies each word.
`timescale 1ns / 1ps

module scd_front import scd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // scan_code[7:0]
	input  logic       s_tuser,  // opcode
	output logic       op_valid,
	input  logic       op_ready,
	output scd_op_t    op_word
);

	logic       shift_q;
	logic       caps_q;
	logic       ctrl_q;
	logic       accept;
	logic [7:0] base;
	logic       letter;
	logic       use_shift;
	logic [7:0] ch_mapped;
	logic [7:0] ch_final;

	assign s_tready = op_ready;
	assign accept   = s_tvalid && s_tready;
	assign op_valid = s_tvalid;

	always_comb begin
		base      = plain_map(s_tdata[6:0]);
		letter    = base >= 8'h61 && base <= 8'h7A;
		use_shift = letter ? (shift_q != caps_q) : shift_q;
		ch_mapped = use_shift ? shifted_map(s_tdata[6:0]) : base;
		ch_final  = ch_mapped;
		if (ctrl_q) begin
			if (ch_mapped >= 8'h61 && ch_mapped <= 8'h7A) begin
				ch_final = ch_mapped - 8'h60;
			end else if (ch_mapped >= 8'h41 && ch_mapped <= 8'h5A) begin
				ch_final = ch_mapped - 8'h40;
			end
		end
	end

	always_comb begin
		op_word      = '0;
		op_word.kind = KIND_NONE;
		op_word.ch   = ch_final;
		priority if (s_tuser) begin
			op_word.kind = KIND_READ;
		end else if (s_tdata == SC_CAPS || s_tdata == SC_LSHIFT || s_tdata == SC_RSHIFT
				|| s_tdata == SC_LCTRL || s_tdata == SC_LSHIFT_BRK
				|| s_tdata == SC_RSHIFT_BRK || s_tdata == SC_LCTRL_BRK
				|| s_tdata[7]) begin
			op_word.kind = KIND_NONE;
		end else if (ctrl_q && ch_final == CH_CTRL_L) begin
			op_word.clr = 1'b1;
		end else begin
			op_word.kind = KIND_PUSH;
			op_word.intr = ctrl_q && ch_final == CH_CTRL_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			ctrl_q  <= 1'b0;
		end else if (accept && !s_tuser) begin
			unique case (s_tdata)
				SC_CAPS: begin
					caps_q <= !caps_q;
				end
				SC_LSHIFT, SC_RSHIFT: begin
					shift_q <= 1'b1;
				end
				SC_LCTRL: begin
					ctrl_q <= 1'b1;
				end
				SC_LSHIFT_BRK, SC_RSHIFT_BRK: begin
					shift_q <= 1'b0;
				end
				SC_LCTRL_BRK: begin
					ctrl_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/scd_queue.sv -----
// Two-entry queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module scd_queue import scd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  scd_op_t in_word,
	output logic    out_valid,
	input  logic    out_ready,
	output scd_op_t out_word
);

	scd_op_t    entry_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_word  = entry_q[rd_idx_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= !wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= !rd_idx_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/scd_back.sv -----
// Back end: character store, pointers and the registered result word.
`timescale 1ns / 1ps

module scd_back import scd_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  scd_op_t     op_word,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [7:0]    mem [FIFO_DEPTH];
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic          out_valid_q;
	logic          rdv_q;
	logic [7:0]    rd_data_q;
	logic          intr_q;
	logic          clr_q;
	logic          drop_q;
	logic [6:0]    fill_q;
	logic          take;
	logic          is_read;
	logic          is_push;
	logic          full;
	logic          empty;
	logic          do_pop;
	logic          do_push;
	logic [7:0]    read_char;

	assign op_ready = !out_valid_q || m_tready;
	assign take     = op_valid && op_ready;
	assign is_read  = op_word.kind == KIND_READ;
	assign is_push  = op_word.kind == KIND_PUSH;
	assign full     = cnt_q == CW'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_pop   = take && is_read && !empty;
	assign do_push  = take && is_push && !full;

	always_comb begin
		cnt_next = cnt_q;
		if (do_pop) begin
			cnt_next = cnt_q - CW'(1);
		end else if (do_push) begin
			cnt_next = cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= op_word.ch;
		end
		if (take) begin
			rd_data_q <= mem[rd_ptr_q];
			rdv_q     <= do_pop;
			intr_q    <= is_push && op_word.intr;
			clr_q     <= !is_read && op_word.clr;
			drop_q    <= is_push && full;
			fill_q    <= 7'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign read_char = rdv_q ? rd_data_q : 8'h00;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'd0, fill_q, drop_q, clr_q, intr_q, read_char, rdv_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FIFO_DEPTH))
		else $error("character count above depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("read did not lower the count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_push && full |=> drop_q && cnt_q == $past(cnt_q))
		else $error("full store did not drop the character");

	a_push_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		take && !do_push |=> wr_ptr_q == $past(wr_ptr_q))
		else $error("write pointer moved without a store");

endmodule

// ----- rtl/scan_code_to_ascii_with_fifo_core.sv -----
// Top level of the set-1 scan code to character decoder with character store.
// A word is accepted every cycle while the queue has room; throughput is one word per cycle.
// The classified word enters the queue, then the store stage registers the result.
// The back end's single store port does one push or one pop per word.
// Reset clears the modifier flags, the queue and the store pointers; no clearing pass is run.
`timescale 1ns / 1ps

module scan_code_to_ascii_with_fifo_core import scd_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // scan_code[7:0]
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_valid[0], read_char[8:1], interrupt_event[9], clear_event[10],
	// char_dropped[11], fill_level[18:12], zero fill[23:19]
	output logic [23:0] m_tdata
);

	logic    f_valid;
	logic    f_ready;
	scd_op_t f_word;
	logic    b_valid;
	logic    b_ready;
	scd_op_t b_word;

	scd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op_word  (f_word)
	);

	scd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_word   (f_word),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_word  (b_word)
	);

	scd_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (b_valid),
		.op_ready (b_ready),
		.op_word  (b_word),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
